/* design/rps_pkg.sv */
// Shared types and codes for the ranked pair sampler.
// No dependencies; used by ranked_pair_sampler.
package rps_pkg;

	// Field widths fixed by the stream format
	localparam int TOTAL_W = 15;
	localparam int INDEX_W = 14;
	localparam int KEY_W   = 32;
	localparam int ID_W    = 32;
	localparam int POS_W   = 8;
	// Signed width for position arithmetic
	localparam int PW      = 17;

	localparam logic [TOTAL_W-1:0] TOTAL_CAP = 15'h7FFF;

	// Request kinds
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_BUILD = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	// Result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_NO_PAIRS = 2'd2;
	localparam logic [1:0] STAT_RANGE    = 2'd3;

	// Sequencer states, one-hot
	typedef enum logic [16:0] {
		ST_IDLE       = 17'h00001,
		ST_SORT_OUTER = 17'h00002,
		ST_SORT_FETCH = 17'h00004,
		ST_SORT_RD    = 17'h00008,
		ST_SORT_CMP   = 17'h00010,
		ST_TBL_START  = 17'h00020,
		ST_TBL_PRIME  = 17'h00040,
		ST_TBL_RD     = 17'h00080,
		ST_TBL_CMP    = 17'h00100,
		ST_TBL_ADD    = 17'h00200,
		ST_Q_RD       = 17'h00400,
		ST_Q_CHK      = 17'h00800,
		ST_Q_DIV      = 17'h01000,
		ST_Q_POS      = 17'h02000,
		ST_Q_HID      = 17'h04000,
		ST_Q_LID      = 17'h08000,
		ST_DONE       = 17'h10000
	} state_t;

endpackage

/* design/ranked_pair_sampler.sv */
// Ranked pair sampler top level: item store, in-place sort, block table, query.
// Depends on rps_pkg and rps_ram.
//
// Channel   Dir  tuser           tdata (low bit up)
// s_axis    in   mode[1:0]       item_id[31:0] target_key[63:32] pick_index[77:64]
// m_axis    out  status[1:0]     high_position[7:0] low_position[15:8] high_id[47:16]
//                                low_id[79:48] total_pairs[94:80]
//
// A query's time is set by the scan up to the table entry found and by the
// 15-step restoring divider.
// A build runs an insertion sort over the item memory (item moves are paced by
// its single read port) then one table pass over the items.
// Reset clears the state, counters and flags only; memories hold no reset value.
// A request is taken while the previous result still waits on m_axis.
module ranked_pair_sampler #(
	parameter int MAX_ITEMS = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [79:0]  s_tdata,  // item_id, target_key, pick_index, pad
	input  logic [1:0]   s_tuser,  // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,  // high_position, low_position, high_id, low_id,
	                               // total_pairs, pad
	output logic [1:0]   m_tuser   // status
);

	localparam int AW  = $clog2(MAX_ITEMS);
	localparam int CW  = $clog2(MAX_ITEMS + 1);
	localparam int PRW = 2 * CW;
	localparam int SW  = ((PRW > rps_pkg::TOTAL_W) ? PRW : rps_pkg::TOTAL_W) + 1;

	rps_pkg::state_t state_q;

	logic [CW-1:0]  count_q, bcount_q, i_q, j_q, last_q, size_q, k_q;
	logic [rps_pkg::TOTAL_W-1:0] total_q;
	logic           built_q;
	logic [31:0]    cur_id_q;
	logic signed [31:0] cur_key_q, prev_key_q;
	logic [PRW-1:0] prod_s1;
	logic [rps_pkg::INDEX_W-1:0] idx_q;
	logic [CW-1:0]  rem_q, dsize_q;
	logic [rps_pkg::TOTAL_W-1:0] quo_q;
	logic [3:0]     dcnt_q;
	logic [AW-1:0]  dstart_q, hp_q, lp_q;
	logic [31:0]    hid_q, lid_q;
	logic [1:0]     status_q;
	logic           m_tvalid_q;
	logic [95:0]    m_tdata_q;
	logic [1:0]     m_tuser_q;

	// Input fields
	logic [1:0]  in_mode;
	logic [31:0] in_id;
	logic [31:0] in_key;
	logic [rps_pkg::INDEX_W-1:0] in_idx;
	logic        accept;
	assign in_mode = s_tuser;
	assign in_id   = s_tdata[31:0];
	assign in_key  = s_tdata[63:32];
	assign in_idx  = s_tdata[77:64];
	assign s_tready = (state_q == rps_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Item memories
	logic          it_we;
	logic [AW-1:0] it_waddr, it_raddr;
	logic [31:0]   it_wid, it_wkey, it_rid;
	logic signed [31:0] it_rkey;

	rps_ram #(.WIDTH(rps_pkg::ID_W), .DEPTH(MAX_ITEMS)) u_ids (
		.clk(clk), .we(it_we), .waddr(it_waddr), .wdata(it_wid),
		.raddr(it_raddr), .rdata(it_rid)
	);
	rps_ram #(.WIDTH(rps_pkg::KEY_W), .DEPTH(MAX_ITEMS)) u_keys (
		.clk(clk), .we(it_we), .waddr(it_waddr), .wdata(it_wkey),
		.raddr(it_raddr), .rdata(it_rkey)
	);

	// Block table memories
	logic          bk_we;
	logic [AW-1:0] bk_waddr, bk_raddr;
	logic [rps_pkg::TOTAL_W-1:0] bk_wtot, bk_rtot;
	logic [CW-1:0] bk_rsize;
	logic [AW-1:0] bk_rstart;

	rps_ram #(.WIDTH(rps_pkg::TOTAL_W), .DEPTH(MAX_ITEMS)) u_totals (
		.clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wtot),
		.raddr(bk_raddr), .rdata(bk_rtot)
	);
	rps_ram #(.WIDTH(CW), .DEPTH(MAX_ITEMS)) u_sizes (
		.clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(size_q),
		.raddr(bk_raddr), .rdata(bk_rsize)
	);
	rps_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_starts (
		.clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(i_q[AW-1:0]),
		.raddr(bk_raddr), .rdata(bk_rstart)
	);

	// Datapath helpers
	logic          not_full, key_gt;
	logic [SW-1:0] sum;
	logic [CW:0]   trial;
	logic          trial_ge;
	logic [rps_pkg::PW-1:0] hp_w, lp_w;
	logic          pos_ok;

	assign not_full = (count_q < CW'(MAX_ITEMS));
	assign key_gt   = (cur_key_q > it_rkey);
	assign sum      = SW'(total_q) + SW'(prod_s1);
	assign bk_wtot  = (sum > SW'(rps_pkg::TOTAL_CAP)) ? rps_pkg::TOTAL_CAP
	                                                   : sum[rps_pkg::TOTAL_W-1:0];
	assign bk_we    = (state_q == rps_pkg::ST_TBL_ADD);
	assign bk_waddr = bcount_q[AW-1:0];
	assign bk_raddr = k_q[AW-1:0];
	assign trial    = {rem_q, quo_q[rps_pkg::TOTAL_W-1]};
	assign trial_ge = (trial >= {1'b0, dsize_q});
	assign hp_w     = rps_pkg::PW'(dstart_q) - rps_pkg::PW'(1) - rps_pkg::PW'(rem_q);
	assign lp_w     = rps_pkg::PW'(dstart_q) + rps_pkg::PW'(quo_q);
	assign pos_ok   = !hp_w[rps_pkg::PW-1] && (hp_w < rps_pkg::PW'(count_q))
	                  && (lp_w < rps_pkg::PW'(count_q));

	// Item memory port control
	always_comb begin
		it_we    = 1'b0;
		it_waddr = j_q[AW-1:0];
		it_wid   = cur_id_q;
		it_wkey  = cur_key_q;
		it_raddr = i_q[AW-1:0];
		case (state_q)
			rps_pkg::ST_IDLE: begin
				it_waddr = count_q[AW-1:0];
				it_wid   = in_id;
				it_wkey  = in_key;
				it_we    = accept && (in_mode == rps_pkg::MODE_LOAD) && not_full;
			end
			rps_pkg::ST_SORT_RD: begin
				it_raddr = AW'(j_q - CW'(1));
				it_we    = (j_q == '0);
			end
			rps_pkg::ST_SORT_CMP: begin
				it_we = 1'b1;
				if (key_gt) begin
					it_wid  = it_rid;
					it_wkey = it_rkey;
				end
			end
			rps_pkg::ST_TBL_START: it_raddr = '0;
			rps_pkg::ST_Q_POS:     it_raddr = hp_w[AW-1:0];
			rps_pkg::ST_Q_HID:     it_raddr = lp_q;
			default: it_raddr = i_q[AW-1:0];
		endcase
	end

	// Sequencer and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rps_pkg::ST_IDLE;
			count_q    <= '0;
			bcount_q   <= '0;
			total_q    <= '0;
			built_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// Drain the output register unless a new result loads it
			if (m_tvalid_q && m_tready && (state_q != rps_pkg::ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				rps_pkg::ST_IDLE: begin
					if (accept) begin
						status_q <= rps_pkg::STAT_OK;
						hp_q     <= '0;
						lp_q     <= '0;
						hid_q    <= '0;
						lid_q    <= '0;
						idx_q    <= in_idx;
						case (in_mode)
							rps_pkg::MODE_LOAD: begin
								if (not_full) begin
									count_q  <= count_q + CW'(1);
									bcount_q <= '0;
									total_q  <= '0;
									built_q  <= 1'b0;
								end else begin
									status_q <= rps_pkg::STAT_FULL;
								end
								state_q <= rps_pkg::ST_DONE;
							end
							rps_pkg::MODE_BUILD: begin
								bcount_q <= '0;
								total_q  <= '0;
								built_q  <= 1'b0;
								i_q      <= CW'(1);
								state_q  <= rps_pkg::ST_SORT_OUTER;
							end
							rps_pkg::MODE_QUERY: begin
								k_q <= '0;
								if (!built_q || total_q == '0) begin
									status_q <= rps_pkg::STAT_NO_PAIRS;
									state_q  <= rps_pkg::ST_DONE;
								end else if (rps_pkg::TOTAL_W'(in_idx) >= total_q) begin
									status_q <= rps_pkg::STAT_RANGE;
									state_q  <= rps_pkg::ST_DONE;
								end else begin
									state_q <= rps_pkg::ST_Q_RD;
								end
							end
							default: begin
								count_q  <= '0;
								bcount_q <= '0;
								total_q  <= '0;
								built_q  <= 1'b0;
								state_q  <= rps_pkg::ST_DONE;
							end
						endcase
					end
				end
				// Insertion sort, descending, stable
				rps_pkg::ST_SORT_OUTER: begin
					state_q <= (i_q >= count_q) ? rps_pkg::ST_TBL_START
					                            : rps_pkg::ST_SORT_FETCH;
				end
				rps_pkg::ST_SORT_FETCH: begin
					cur_id_q  <= it_rid;
					cur_key_q <= it_rkey;
					j_q       <= i_q;
					state_q   <= rps_pkg::ST_SORT_RD;
				end
				rps_pkg::ST_SORT_RD: begin
					if (j_q == '0) begin
						i_q     <= i_q + CW'(1);
						state_q <= rps_pkg::ST_SORT_OUTER;
					end else begin
						state_q <= rps_pkg::ST_SORT_CMP;
					end
				end
				rps_pkg::ST_SORT_CMP: begin
					if (key_gt) begin
						j_q     <= j_q - CW'(1);
						state_q <= rps_pkg::ST_SORT_RD;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= rps_pkg::ST_SORT_OUTER;
					end
				end
				// Table pass over sorted keys
				rps_pkg::ST_TBL_START: begin
					i_q     <= CW'(1);
					last_q  <= '0;
					state_q <= rps_pkg::ST_TBL_PRIME;
				end
				rps_pkg::ST_TBL_PRIME: begin
					prev_key_q <= it_rkey;
					state_q    <= rps_pkg::ST_TBL_RD;
				end
				rps_pkg::ST_TBL_RD: begin
					if (i_q >= count_q) begin
						built_q <= 1'b1;
						state_q <= rps_pkg::ST_DONE;
					end else begin
						state_q <= rps_pkg::ST_TBL_CMP;
					end
				end
				rps_pkg::ST_TBL_CMP: begin
					prev_key_q <= it_rkey;
					if (it_rkey != prev_key_q) begin
						size_q  <= i_q - last_q;
						prod_s1 <= PRW'(i_q - last_q) * PRW'(count_q - i_q);
						state_q <= rps_pkg::ST_TBL_ADD;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= rps_pkg::ST_TBL_RD;
					end
				end
				rps_pkg::ST_TBL_ADD: begin
					total_q  <= bk_wtot;
					bcount_q <= bcount_q + CW'(1);
					last_q   <= i_q;
					i_q      <= i_q + CW'(1);
					state_q  <= rps_pkg::ST_TBL_RD;
				end
				// Scan the table for the first total above the index
				rps_pkg::ST_Q_RD: begin
					if (k_q >= bcount_q) begin
						status_q <= rps_pkg::STAT_RANGE;
						state_q  <= rps_pkg::ST_DONE;
					end else begin
						state_q <= rps_pkg::ST_Q_CHK;
					end
				end
				rps_pkg::ST_Q_CHK: begin
					if (bk_rtot <= rps_pkg::TOTAL_W'(idx_q)) begin
						k_q     <= k_q + CW'(1);
						state_q <= rps_pkg::ST_Q_RD;
					end else if (bk_rsize == '0) begin
						status_q <= rps_pkg::STAT_RANGE;
						state_q  <= rps_pkg::ST_DONE;
					end else begin
						quo_q    <= bk_rtot - rps_pkg::TOTAL_W'(idx_q)
						            - rps_pkg::TOTAL_W'(1);
						rem_q    <= '0;
						dcnt_q   <= '0;
						dsize_q  <= bk_rsize;
						dstart_q <= bk_rstart;
						state_q  <= rps_pkg::ST_Q_DIV;
					end
				end
				// Restoring division, one quotient bit per cycle
				rps_pkg::ST_Q_DIV: begin
					rem_q  <= trial_ge ? CW'(trial - {1'b0, dsize_q}) : trial[CW-1:0];
					quo_q  <= {quo_q[rps_pkg::TOTAL_W-2:0], trial_ge};
					dcnt_q <= dcnt_q + 4'd1;
					if (dcnt_q == 4'(rps_pkg::TOTAL_W - 1)) begin
						state_q <= rps_pkg::ST_Q_POS;
					end
				end
				rps_pkg::ST_Q_POS: begin
					if (pos_ok) begin
						hp_q    <= hp_w[AW-1:0];
						lp_q    <= lp_w[AW-1:0];
						state_q <= rps_pkg::ST_Q_HID;
					end else begin
						status_q <= rps_pkg::STAT_RANGE;
						state_q  <= rps_pkg::ST_DONE;
					end
				end
				rps_pkg::ST_Q_HID: begin
					hid_q   <= it_rid;
					state_q <= rps_pkg::ST_Q_LID;
				end
				rps_pkg::ST_Q_LID: begin
					lid_q   <= it_rid;
					state_q <= rps_pkg::ST_DONE;
				end
				// Hand the result to the output register once it is free
				rps_pkg::ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= status_q;
						m_tdata_q  <= {1'b0, total_q, lid_q, hid_q,
						               rps_pkg::POS_W'(lp_q), rps_pkg::POS_W'(hp_q)};
						state_q    <= rps_pkg::ST_IDLE;
					end
				end
				default: state_q <= rps_pkg::ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* design/rps_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module rps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
